[sv/dbled_pkg.sv]
// ---------------------------------------------------------------------------
// Debounced button LED controller package
// Register indexes, reset values, stream widths and the LED state record
// shared by the controller, its checker and the testbench.
// ---------------------------------------------------------------------------
package dbled_pkg;

    localparam int NUM_BUTTONS = 3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int DEB_W       = 8;
    localparam int INTERVAL_W  = 16;
    localparam int ACTIVE_W    = NUM_BUTTONS;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEBOUNCE_TICKS = 2'd0,
        REG_BLINK_INTERVAL = 2'd1,
        REG_ACTIVE_LEVELS  = 2'd2
    } cfg_reg_t;

    localparam logic [DEB_W-1:0]      DEBOUNCE_RESET = 8'd20;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd500;
    localparam logic [ACTIVE_W-1:0]   ACTIVE_RESET   = 3'b001;

    typedef struct packed {
        logic mode;
        logic phase;
        logic led0;
        logic led1;
    } led_state_t;

    localparam led_state_t LED_STATE_RESET = '{mode: 1'b0, phase: 1'b0,
                                               led0: 1'b1, led1: 1'b0};

endpackage

[sv/debounced_button_led_controller.sv]
// ---------------------------------------------------------------------------
// Debounced button LED controller
// Three debounced buttons with latched press detection driving two LEDs that
// blink alternately until the first press and are toggled by presses after.
// ---------------------------------------------------------------------------
//  channel | direction | tdata bits (lowest first)
//  s_      | in        | wake_level, key0_level, key1_level, 5 zero bits
//  m_      | out       | led0_lit, led1_lit, manual_mode, wake_press,
//          |           | key0_press, key1_press, 2 zero bits
//  cfg_    | in        | write only: debounce_ticks, blink_interval, active_levels
//
// One tick transfer is taken per cycle while ready; its result appears in
// the output register on the next cycle. The input side is ready whenever
// the output register is empty or is being drained in the same cycle, so a
// stalled result holds off the input for as long as it waits. Reset is
// synchronous; afterwards every button sits at its inactive level.
// ---------------------------------------------------------------------------
module debounced_button_led_controller #(
    parameter int QUIET_BITS = 8,
    parameter int BLINK_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // wake_level, key0_level, key1_level
    input  logic [dbled_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // led0_lit, led1_lit, manual_mode, wake_press, key0_press, key1_press
    output logic [dbled_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                 cfg_we,
    input  logic [dbled_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dbled_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int NB     = dbled_pkg::NUM_BUTTONS;
    localparam int QCMP_W = (QUIET_BITS > dbled_pkg::DEB_W) ? QUIET_BITS : dbled_pkg::DEB_W;
    localparam int BCMP_W = (BLINK_BITS > dbled_pkg::INTERVAL_W) ?
                            BLINK_BITS : dbled_pkg::INTERVAL_W;
    localparam logic [QUIET_BITS-1:0] QUIET_MAX = '1;
    localparam logic [BLINK_BITS-1:0] BLINK_MAX = '1;

    logic [dbled_pkg::DEB_W-1:0]      deb_ticks_reg;
    logic [dbled_pkg::INTERVAL_W-1:0] interval_reg;
    logic [dbled_pkg::ACTIVE_W-1:0]   active_reg;

    dbled_pkg::led_state_t led_reg, led_next;
    logic [BLINK_BITS-1:0] elapsed_reg, elapsed_next;
    logic [NB-1:0] prior_reg, prior_next;
    logic [NB-1:0] settled_reg, settled_next;
    logic [NB-1:0] held_reg, held_next;
    logic [QUIET_BITS-1:0] quiet_reg [NB];
    logic [QUIET_BITS-1:0] quiet_next [NB];
    logic [NB-1:0] pulse;
    logic [NB-1:0] level;

    logic                           m_valid_reg;
    logic [dbled_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                           accept;
    logic [BLINK_BITS-1:0]          elapsed_inc;
    logic                           blink_hit;
    logic                           phase_new;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign level    = s_tdata[NB-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_ticks_reg <= dbled_pkg::DEBOUNCE_RESET;
            interval_reg  <= dbled_pkg::INTERVAL_RESET;
            active_reg    <= dbled_pkg::ACTIVE_RESET;
        end else if (cfg_we) begin
            unique case (dbled_pkg::cfg_reg_t'(cfg_index))
                dbled_pkg::REG_DEBOUNCE_TICKS: deb_ticks_reg <= cfg_wdata[dbled_pkg::DEB_W-1:0];
                dbled_pkg::REG_BLINK_INTERVAL: interval_reg  <= cfg_wdata;
                dbled_pkg::REG_ACTIVE_LEVELS:  active_reg    <= cfg_wdata[dbled_pkg::ACTIVE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int b = 0; b < NB; b++) begin
            if (level[b] != prior_reg[b]) begin
                quiet_next[b] = '0;
            end else if (quiet_reg[b] != QUIET_MAX) begin
                quiet_next[b] = quiet_reg[b] + 1'b1;
            end else begin
                quiet_next[b] = quiet_reg[b];
            end
            prior_next[b]   = level[b];
            settled_next[b] = settled_reg[b];
            held_next[b]    = held_reg[b];
            pulse[b]        = 1'b0;
            if (QCMP_W'(quiet_next[b]) >= QCMP_W'(deb_ticks_reg)) begin
                settled_next[b] = level[b];
                if (level[b] == active_reg[b]) begin
                    pulse[b]     = (level[b] != settled_reg[b]) && !held_reg[b];
                    held_next[b] = held_reg[b] || (level[b] != settled_reg[b]);
                end else begin
                    held_next[b] = 1'b0;
                end
            end
        end
    end

    assign elapsed_inc = (elapsed_reg != BLINK_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign blink_hit   = BCMP_W'(elapsed_inc) >= BCMP_W'(interval_reg);
    assign phase_new   = !led_reg.phase;

    always_comb begin
        led_next     = led_reg;
        elapsed_next = elapsed_reg;
        if (!led_reg.mode) begin
            elapsed_next = elapsed_inc;
            if (blink_hit) begin
                elapsed_next   = '0;
                led_next.phase = phase_new;
                led_next.led0  = !phase_new;
                led_next.led1  = phase_new;
            end
        end
        led_next.led0 = led_next.led0 ^ pulse[0] ^ pulse[2];
        led_next.led1 = led_next.led1 ^ pulse[1] ^ pulse[2];
        led_next.mode = led_next.mode || (|pulse);
        m_data_next   = {2'b00, pulse, led_next.mode, led_next.led1, led_next.led0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_reg     <= dbled_pkg::LED_STATE_RESET;
            elapsed_reg <= '0;
            prior_reg   <= ~dbled_pkg::ACTIVE_RESET;
            settled_reg <= ~dbled_pkg::ACTIVE_RESET;
            held_reg    <= '0;
            for (int b = 0; b < NB; b++) begin
                quiet_reg[b] <= '0;
            end
        end else if (accept) begin
            led_reg     <= led_next;
            elapsed_reg <= elapsed_next;
            prior_reg   <= prior_next;
            settled_reg <= settled_next;
            held_reg    <= held_next;
            for (int b = 0; b < NB; b++) begin
                quiet_reg[b] <= quiet_next[b];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

[dv/debounced_button_led_controller_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Debounced button LED controller checker
// Watches the tick, result and register ports of the controller. It keeps a
// shadow of the registers and of the debounce, press latch and blink state.
// For every accepted tick transfer it predicts the LED and press outputs. It
// compares every accepted result transfer field by field with the oldest
// prediction, and passes the mismatch count and the number of outstanding
// results to the testbench top.
// ---------------------------------------------------------------------------
module debounced_button_led_controller_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [dbled_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [dbled_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_we,
    input  logic [dbled_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dbled_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                                error_count,
    output int                                pending_results
);

    typedef struct packed {
        logic key1_press;
        logic key0_press;
        logic wake_press;
        logic manual_mode;
        logic led1_lit;
        logic led0_lit;
    } led_result_t;

    logic [dbled_pkg::DEB_W-1:0]      debounce_len;
    logic [dbled_pkg::INTERVAL_W-1:0] blink_len;
    logic [dbled_pkg::ACTIVE_W-1:0]   active_pol;

    logic                             manual;
    logic                             phase;
    logic                             led0;
    logic                             led1;
    logic [dbled_pkg::INTERVAL_W-1:0] blink_count;
    logic [2:0]                       last_raw;
    logic [2:0]                       settled;
    logic [2:0]                       latched;
    logic [dbled_pkg::DEB_W-1:0]      quiet [dbled_pkg::NUM_BUTTONS];

    led_result_t           expected_leds [$];
    int                    mismatches = 0;

    assign error_count = mismatches;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_bit(input string name, input logic got, input logic want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %b, expected %b", name, got, want));
        end
    endtask

    task automatic clear_predictor();
        debounce_len = dbled_pkg::DEBOUNCE_RESET;
        blink_len    = dbled_pkg::INTERVAL_RESET;
        active_pol   = dbled_pkg::ACTIVE_RESET;
        manual       = dbled_pkg::LED_STATE_RESET.mode;
        phase        = dbled_pkg::LED_STATE_RESET.phase;
        led0         = dbled_pkg::LED_STATE_RESET.led0;
        led1         = dbled_pkg::LED_STATE_RESET.led1;
        blink_count  = '0;
        last_raw     = ~dbled_pkg::ACTIVE_RESET;
        settled      = ~dbled_pkg::ACTIVE_RESET;
        latched      = '0;
        for (int b = 0; b < dbled_pkg::NUM_BUTTONS; b++) begin
            quiet[b] = '0;
        end
    endtask

    task automatic settle_button(input int b, input logic raw, output logic pulse);
        pulse = 1'b0;
        if (raw != last_raw[b]) begin
            last_raw[b] = raw;
            quiet[b]    = '0;
        end else if (quiet[b] != '1) begin
            quiet[b] = quiet[b] + 1'b1;
        end
        if (quiet[b] >= debounce_len) begin
            if (raw != settled[b]) begin
                settled[b] = raw;
                if (raw == active_pol[b]) begin
                    if (!latched[b]) begin
                        latched[b] = 1'b1;
                        pulse      = 1'b1;
                    end
                end else begin
                    latched[b] = 1'b0;
                end
            end
            if (settled[b] != active_pol[b]) begin
                latched[b] = 1'b0;
            end
        end
    endtask

    task automatic advance_tick(input logic [2:0] raw, output led_result_t res);
        logic wake_hit;
        logic key0_hit;
        logic key1_hit;
        if (!manual) begin
            if (blink_count != '1) begin
                blink_count = blink_count + 1'b1;
            end
            if (blink_count >= blink_len) begin
                blink_count = '0;
                phase       = ~phase;
                led0        = ~phase;
                led1        = phase;
            end
        end
        settle_button(0, raw[0], wake_hit);
        if (wake_hit) begin
            manual = 1'b1;
            led0   = ~led0;
        end
        settle_button(1, raw[1], key0_hit);
        if (key0_hit) begin
            manual = 1'b1;
            led1   = ~led1;
        end
        settle_button(2, raw[2], key1_hit);
        if (key1_hit) begin
            manual = 1'b1;
            led0   = ~led0;
            led1   = ~led1;
        end
        res.led0_lit    = led0;
        res.led1_lit    = led1;
        res.manual_mode = manual;
        res.wake_press  = wake_hit;
        res.key0_press  = key0_hit;
        res.key1_press  = key1_hit;
    endtask

    always @(posedge aclk) begin : watch
        led_result_t got;
        led_result_t want;
        if (!aresetn) begin
            clear_predictor();
            expected_leds.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = led_result_t'(m_tdata[5:0]);
                if (expected_leds.size() == 0) begin
                    report_mismatch($sformatf("unexpected result transfer %b", m_tdata));
                end else begin
                    want = expected_leds.pop_front();
                    compare_bit("led0_lit", got.led0_lit, want.led0_lit);
                    compare_bit("led1_lit", got.led1_lit, want.led1_lit);
                    compare_bit("manual_mode", got.manual_mode, want.manual_mode);
                    compare_bit("wake_press", got.wake_press, want.wake_press);
                    compare_bit("key0_press", got.key0_press, want.key0_press);
                    compare_bit("key1_press", got.key1_press, want.key1_press);
                    if (m_tdata[dbled_pkg::M_TDATA_W-1:6] !== '0) begin
                        report_mismatch($sformatf("padding bits are %b",
                                                  m_tdata[dbled_pkg::M_TDATA_W-1:6]));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                advance_tick(s_tdata[2:0], want);
                expected_leds.push_back(want);
            end
            if (cfg_we) begin
                case (dbled_pkg::cfg_reg_t'(cfg_index))
                    dbled_pkg::REG_DEBOUNCE_TICKS:
                        debounce_len = cfg_wdata[dbled_pkg::DEB_W-1:0];
                    dbled_pkg::REG_BLINK_INTERVAL:
                        blink_len    = cfg_wdata[dbled_pkg::INTERVAL_W-1:0];
                    dbled_pkg::REG_ACTIVE_LEVELS:
                        active_pol   = cfg_wdata[dbled_pkg::ACTIVE_W-1:0];
                    default: ;
                endcase
            end
        end
        pending_results <= expected_leds.size();
    end

endmodule

[dv/debounced_button_led_controller_test.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Debounced button LED controller testbench
// Drives tick transfers carrying raw button levels into the controller and
// programs its registers between phases while it is idle. A short directed
// sequence covers auto blinking, glitch rejection and zero debounce. Random
// phases then apply debounced press and release patterns mixed with bounce
// and noise under several register settings, with random stalls on both
// channels. The checker predicts and compares every result transfer.
// ---------------------------------------------------------------------------
module debounced_button_led_controller_test;

    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [dbled_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [dbled_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                              cfg_we    = 1'b0;
    logic [dbled_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [dbled_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    int error_count;
    int pending_results;
    int src_idle_pct  = 28;
    int sink_idle_pct = 87;

    debounced_button_led_controller i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    debounced_button_led_controller_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Bit 0 is wake, bit 1 is key 0, bit 2 is key 1.
    task automatic send_tick(input logic [2:0] levels);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(dbled_pkg::S_TDATA_W-3){1'b0}}, levels};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic load_settings(input logic [dbled_pkg::DEB_W-1:0] deb,
                                 input logic [dbled_pkg::INTERVAL_W-1:0] interval,
                                 input logic [dbled_pkg::ACTIVE_W-1:0] act);
        cfg_we    <= 1'b1;
        cfg_index <= dbled_pkg::REG_DEBOUNCE_TICKS;
        cfg_wdata <= dbled_pkg::CFG_DATA_W'(deb);
        @(posedge aclk);
        cfg_index <= dbled_pkg::REG_BLINK_INTERVAL;
        cfg_wdata <= dbled_pkg::CFG_DATA_W'(interval);
        @(posedge aclk);
        cfg_index <= dbled_pkg::REG_ACTIVE_LEVELS;
        cfg_wdata <= dbled_pkg::CFG_DATA_W'(act);
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Most bursts hold one level set long enough to settle, some fall one
    // tick short, and a few are pure noise.
    task automatic press_bursts(input int deb, input int budget);
        int sent;
        int hold;
        logic [2:0] target;
        sent = 0;
        while (sent < budget) begin
            target = 3'($urandom);
            if ($urandom_range(9) < 2) begin
                repeat ($urandom_range(1, 3)) begin
                    send_tick(3'($urandom));
                    sent++;
                end
            end else begin
                repeat ($urandom_range(0, 2)) begin
                    send_tick(3'($urandom));
                    sent++;
                end
                hold = deb + 1 + $urandom_range(0, 2);
                if ($urandom_range(5) == 0) begin
                    hold = (deb > 0) ? deb : 1;
                end
                repeat (hold) send_tick(target);
                sent += hold;
            end
        end
    endtask

    initial begin : stimulus
        logic [dbled_pkg::DEB_W-1:0]    deb;
        logic [dbled_pkg::ACTIVE_W-1:0] act;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // At the reset settings a short glitch must not be accepted.
        send_tick(3'b110);
        send_tick(3'b110);
        send_tick(3'b001);
        send_tick(3'b001);
        send_tick(3'b110);
        drain_results();

        // Blinking on every tick, then the widest interval, then an interval of one.
        load_settings(8'd255, 16'd0, 3'b001);
        repeat (3) send_tick(3'b110);
        drain_results();
        load_settings(8'd255, 16'hFFFF, 3'b001);
        repeat (2) send_tick(3'b110);
        drain_results();
        load_settings(8'd255, 16'd1, 3'b001);
        repeat (2) send_tick(3'b110);
        drain_results();

        // With zero debounce every level is taken at once.
        load_settings(8'd0, 16'd3, 3'b001);
        send_tick(3'b111);
        send_tick(3'b101);
        send_tick(3'b001);
        send_tick(3'b001);
        send_tick(3'b110);
        send_tick(3'b001);
        send_tick(3'b110);
        drain_results();

        for (int p = 0; p < 11; p++) begin
            if (p == 4) begin
                src_idle_pct  = 87;
                sink_idle_pct = 28;
            end else if (p == 8) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            case (p)
                0:       act = 3'b000;
                1:       act = 3'b111;
                default: act = 3'($urandom);
            endcase
            if (p == 10) begin
                deb = 8'd255;
            end else if (p == 2) begin
                deb = 8'd1;
            end else begin
                deb = 8'($urandom_range(0, 4));
            end
            load_settings(deb, (p == 3) ? 16'hFFFF : 16'($urandom), act);
            press_bursts(deb, (p == 10) ? 150 : 50);
            drain_results();
        end

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
